>>> sv/fccm_pkg.sv
// Shared types and constants of the cluster chain manager.
`default_nettype none

package fccm_pkg;

	// Command codes carried in the slave-side tuser
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_ALLOC = 2'd2,
		CMD_FREE  = 2'd3
	} cmd_t;

	// Result status carried in the master-side tuser
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] REG_CLUSTER_LIMIT   = 2'd0;
	localparam logic [1:0] REG_DATA_START      = 2'd1;
	localparam logic [1:0] REG_CLUSTER_SECTORS = 2'd2;

	// Configuration reset values
	localparam logic [15:0] LIMIT_RESET   = 16'd4096;
	localparam logic [31:0] START_RESET   = 32'd0;
	localparam logic [7:0]  SECTORS_RESET = 8'd4;

	// Table entry codes
	localparam logic [15:0] EOC_MARK    = 16'hFFF8;
	localparam logic [15:0] ENTRY0_INIT = 16'hFFF8;
	localparam logic [15:0] ENTRY1_INIT = 16'hFFFF;
	localparam logic [15:0] ALLOC_CEIL  = 16'hFFF0;
	localparam logic [15:0] FIRST_DATA  = 16'd2;

	// Controller states
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_RD_WAIT,
		S_AL_SCAN,
		S_AL_MARK,
		S_FR_RD,
		S_FR_WR,
		S_FINISH
	} state_t;

	// Write data select for the table
	typedef enum logic [1:0] {
		W_INIT,
		W_VAL,
		W_EOC,
		W_ZERO
	} wsel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    accept;
		logic    cur_inc;
		logic    cur_from_cand;
		logic    cur_from_rdata;
		logic    mem_re;
		logic    mem_we;
		wsel_t   wsel;
		logic    ev_from_rdata;
		logic    ev_from_cur;
		logic    sa_en;
		logic    st_set;
		status_t st_code;
		logic    out_load;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic oor;
		logic clr_last;
		logic hit;
		logic at_bound;
		logic link_end;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> sv/fccm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fccm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/fccm_ctrl.sv
// Controller state machine: sequences clearing, command steps and result hand-off.
`default_nettype none

module fccm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire fccm_pkg::dp_stat_t stat,
	output fccm_pkg::ctl_cmd_t     cmd
);

	fccm_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fccm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.wsel    = fccm_pkg::W_ZERO;
		cmd.st_code = fccm_pkg::ST_OK;
		unique case (state_q)
			fccm_pkg::S_CLEAR: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = fccm_pkg::W_INIT;
				cmd.cur_inc = 1'b1;
				if (stat.clr_last) begin
					state_d = fccm_pkg::S_IDLE;
				end
			end
			fccm_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = fccm_pkg::S_DISPATCH;
				end
			end
			fccm_pkg::S_DISPATCH: begin
				unique case (stat.cmd)
					fccm_pkg::CMD_READ: begin
						if (stat.oor) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = fccm_pkg::ST_RANGE;
							state_d     = fccm_pkg::S_FINISH;
						end else begin
							cmd.mem_re = 1'b1;
							state_d    = fccm_pkg::S_RD_WAIT;
						end
					end
					fccm_pkg::CMD_WRITE: begin
						if (stat.oor) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = fccm_pkg::ST_RANGE;
						end else begin
							cmd.mem_we = 1'b1;
							cmd.wsel   = fccm_pkg::W_VAL;
						end
						state_d = fccm_pkg::S_FINISH;
					end
					fccm_pkg::CMD_ALLOC: begin
						state_d = fccm_pkg::S_AL_SCAN;
					end
					fccm_pkg::CMD_FREE: begin
						if (stat.oor) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = fccm_pkg::ST_RANGE;
							state_d     = fccm_pkg::S_FINISH;
						end else begin
							state_d = fccm_pkg::S_FR_RD;
						end
					end
				endcase
			end
			fccm_pkg::S_RD_WAIT: begin
				cmd.ev_from_rdata = 1'b1;
				cmd.sa_en         = 1'b1;
				state_d           = fccm_pkg::S_FINISH;
			end
			// Pipelined scan: read issued each cycle, checked the next
			fccm_pkg::S_AL_SCAN: begin
				priority if (stat.hit) begin
					cmd.cur_from_cand = 1'b1;
					state_d           = fccm_pkg::S_AL_MARK;
				end else if (stat.at_bound) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = fccm_pkg::ST_FULL;
					state_d     = fccm_pkg::S_FINISH;
				end else begin
					cmd.mem_re  = 1'b1;
					cmd.cur_inc = 1'b1;
				end
			end
			fccm_pkg::S_AL_MARK: begin
				cmd.mem_we      = 1'b1;
				cmd.wsel        = fccm_pkg::W_EOC;
				cmd.ev_from_cur = 1'b1;
				cmd.sa_en       = 1'b1;
				state_d         = fccm_pkg::S_FINISH;
			end
			// Chain walk: read the link, then zero the entry and follow it
			fccm_pkg::S_FR_RD: begin
				if (stat.link_end) begin
					state_d = fccm_pkg::S_FINISH;
				end else begin
					cmd.mem_re = 1'b1;
					state_d    = fccm_pkg::S_FR_WR;
				end
			end
			fccm_pkg::S_FR_WR: begin
				cmd.mem_we         = 1'b1;
				cmd.wsel           = fccm_pkg::W_ZERO;
				cmd.cur_from_rdata = 1'b1;
				state_d            = fccm_pkg::S_FR_RD;
			end
			fccm_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = fccm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fccm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sv/fccm_dp.sv
// Datapath: configuration registers, table cursor, address arithmetic and result register.
`default_nettype none

module fccm_dp #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration writes
	input  wire logic               cfg_valid,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	// command payload
	input  wire logic [1:0]         in_command,
	input  wire logic [15:0]        in_cluster,
	input  wire logic [15:0]        in_value,
	// result channel
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             out_entry_value,
	output logic [31:0]             out_sector_address,
	output logic [1:0]              out_status,
	// controller link
	input  wire fccm_pkg::ctl_cmd_t cmd,
	output fccm_pkg::dp_stat_t      stat
);

	localparam int          AW      = $clog2(TABLE_ENTRIES);
	localparam logic [16:0] N17     = 17'(TABLE_ENTRIES);
	localparam logic [15:0] N16     = 16'(TABLE_ENTRIES);
	localparam logic [15:0] LAST_IX = 16'(TABLE_ENTRIES - 1);

	logic [15:0]       limit_q;
	logic [31:0]       start_q;
	logic [7:0]        sectors_q;
	logic [1:0]        cmd_q;
	logic [15:0]       val_q;
	logic              oor_q;
	logic [15:0]       bound_q;
	logic [15:0]       cur_q;
	logic [15:0]       cand_q;
	logic              rv_q;
	logic [15:0]       ev_q;
	logic [1:0]        st_q;
	logic              sa_en_q;
	logic [31:0]       prod_q;
	logic [15:0]       bound_d;
	logic [31:0]       diff;
	logic [31:0]       prod_d;
	logic [15:0]       wdata;
	logic [15:0]       rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= fccm_pkg::LIMIT_RESET;
			start_q   <= fccm_pkg::START_RESET;
			sectors_q <= fccm_pkg::SECTORS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fccm_pkg::REG_CLUSTER_LIMIT:   limit_q   <= cfg_data[15:0];
				fccm_pkg::REG_DATA_START:      start_q   <= cfg_data;
				fccm_pkg::REG_CLUSTER_SECTORS: sectors_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Scan bound: smallest of limit, ceiling and table size
	always_comb begin
		bound_d = limit_q;
		if (bound_d > fccm_pkg::ALLOC_CEIL) begin
			bound_d = fccm_pkg::ALLOC_CEIL;
		end
		if (bound_d > N16) begin
			bound_d = N16;
		end
	end

	// Captured command fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q   <= in_command;
			val_q   <= in_value;
			oor_q   <= {1'b0, in_cluster} >= N17;
			bound_q <= bound_d;
		end
	end

	// Cursor: clear counter, scan pointer and chain position in one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			rv_q <= cmd.mem_re;
			priority if (cmd.accept) begin
				cur_q <= (fccm_pkg::cmd_t'(in_command) == fccm_pkg::CMD_ALLOC)
					? fccm_pkg::FIRST_DATA : in_cluster;
			end else if (cmd.cur_from_cand) begin
				cur_q <= cand_q;
			end else if (cmd.cur_from_rdata) begin
				cur_q <= rdata;
			end else if (cmd.cur_inc) begin
				cur_q <= cur_q + 16'd1;
			end
		end
	end

	// Address of the read in flight during a scan
	always_ff @(posedge clk) begin
		if (cmd.mem_re) begin
			cand_q <= cur_q;
		end
	end

	// Table write data
	always_comb begin
		unique case (cmd.wsel)
			fccm_pkg::W_INIT: begin
				if (cur_q == 16'd0) begin
					wdata = fccm_pkg::ENTRY0_INIT;
				end else if (cur_q == 16'd1) begin
					wdata = fccm_pkg::ENTRY1_INIT;
				end else begin
					wdata = '0;
				end
			end
			fccm_pkg::W_VAL:  wdata = val_q;
			fccm_pkg::W_EOC:  wdata = fccm_pkg::EOC_MARK;
			fccm_pkg::W_ZERO: wdata = '0;
			default:          wdata = '0;
		endcase
	end

	fccm_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (cmd.mem_we),
		.waddr (cur_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.mem_re),
		.raddr (cur_q[AW-1:0]),
		.rdata (rdata)
	);

	// Sector offset: one registered multiply, the add follows at result load
	assign diff   = {16'd0, cur_q} - 32'd2;
	assign prod_d = diff * {24'd0, sectors_q};

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	// Pending result fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ev_q    <= '0;
			st_q    <= fccm_pkg::ST_OK;
			sa_en_q <= 1'b0;
		end else begin
			if (cmd.ev_from_rdata) begin
				ev_q <= rdata;
			end else if (cmd.ev_from_cur) begin
				ev_q <= cur_q;
			end
			if (cmd.st_set) begin
				st_q <= cmd.st_code;
			end
			if (cmd.sa_en) begin
				sa_en_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_entry_value    <= ev_q;
			out_sector_address <= sa_en_q ? (start_q + prod_q) : 32'd0;
			out_status         <= st_q;
		end
	end

	// Status to the controller
	always_comb begin
		stat.cmd      = fccm_pkg::cmd_t'(cmd_q);
		stat.oor      = oor_q;
		stat.clr_last = (cur_q == LAST_IX);
		stat.hit      = rv_q && (rdata == 16'd0);
		stat.at_bound = (cur_q >= bound_q);
		stat.link_end = (cur_q < fccm_pkg::FIRST_DATA) || (cur_q >= fccm_pkg::EOC_MARK)
			|| (cur_q >= N16);
		stat.out_free = !m_tvalid || m_tready;
	end

endmodule

`default_nettype wire

>>> sv/fat16_cluster_chain_manager.sv
// Top level of the FAT16 cluster chain manager: controller, datapath and ports.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tuser: command; tdata: cluster, value
//  m_*       out        m_tvalid / m_tready  tdata: entry_value, sector_address; tuser: status
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (ready always high)
//
// After reset a clearing pass writes every table entry with s_tready low;
// configuration writes are taken throughout. Allocate scans for the first free entry,
// one table read per cycle, up to the scan bound; free walks the chain, with a read
// then a write of each entry on the one table port pair.
// One command is in work at a time; a finished result waits in the output register
// while the next command is taken, and a stalled result holds back the one after.
`default_nettype none

module fat16_cluster_chain_manager #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] cluster, [31:16] value
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] entry_value, [47:16] sector_address
	output logic [1:0]       m_tuser,   // [1:0] status
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	fccm_pkg::ctl_cmd_t cmd;
	fccm_pkg::dp_stat_t stat;
	logic [15:0]        entry_value;
	logic [31:0]        sector_address;

	assign cfg_ready = 1'b1;

	fccm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fccm_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_command         (s_tuser),
		.in_cluster         (s_tdata[15:0]),
		.in_value           (s_tdata[31:16]),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.out_entry_value    (entry_value),
		.out_sector_address (sector_address),
		.out_status         (m_tuser),
		.cmd                (cmd),
		.stat               (stat)
	);

	assign m_tdata = {sector_address, entry_value};

endmodule

`default_nettype wire

>>> sv/fccm_chk.sv
// Port-level checker for the cluster chain manager, bound to the top level.
`default_nettype none

module fccm_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Failed commands carry no entry or sector
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == fccm_pkg::ST_FULL || m_tuser == fccm_pkg::ST_RANGE)
		|-> m_tdata == 48'd0)
		else $error("non-zero payload on failed command");

	// Table clearing runs first after reset
	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !s_tready)
		else $error("command taken during clearing pass");

	// One command in work at a time
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in work");

endmodule

bind fat16_cluster_chain_manager fccm_chk u_fccm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
